// ===== hdl/bmhq_pkg.sv =====
// Shared types and constants for the binary max-heap queue core.
// Used by bmhq_cmp and binary_max_heap_queue_core; depends on nothing.
`default_nettype none

package bmhq_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF     = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int KEY_PORT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 11;

    // Request types
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Operand selection of the shared comparator
    typedef enum logic [1:0] {
        CMP_UP    = 2'd0,   // parent < sifting key
        CMP_CHILD = 2'd1,   // left child < right child
        CMP_KEY   = 2'd2    // sifting key < picked child
    } t_cmp_sel;

endpackage

`default_nettype wire

// ===== hdl/bmhq_cmp.sv =====
// Shared unsigned less-than unit with operand selection for sift steps.
// Depends on bmhq_pkg for t_cmp_sel.
`default_nettype none

module bmhq_cmp
    import bmhq_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire t_cmp_sel             i_sel,
    input  wire logic [KEY_WIDTH-1:0] i_rdata,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic [KEY_WIDTH-1:0] i_pick,
    output logic                      o_lt
);

    logic [KEY_WIDTH-1:0] w_a;
    logic [KEY_WIDTH-1:0] w_b;

    always_comb begin
        unique case (i_sel)
            CMP_UP: begin
                w_a = i_rdata;
                w_b = i_key;
            end
            CMP_CHILD: begin
                w_a = i_pick;
                w_b = i_rdata;
            end
            CMP_KEY: begin
                w_a = i_key;
                w_b = i_pick;
            end
            default: begin
                w_a = i_rdata;
                w_b = i_key;
            end
        endcase
    end

    assign o_lt = (w_a < w_b);

endmodule

`default_nettype wire

// ===== hdl/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap priority queue: sequencer, heap store, output register.
// Depends on bmhq_pkg and bmhq_cmp.
`default_nettype none

// Binary max-heap priority queue of unsigned keys. Each request is an insert
// (req_type 0) or a pop (req_type 1) and yields exactly one result carrying
// the popped key (zero unless a pop succeeds), a status (ok, insert dropped
// because full, pop on empty) and the occupancy after the request. The heap
// lives in a single memory of DEPTH entries with one write and one registered
// read port; at reset the store is not cleared, only the key count, state and
// output valid flag are. One request is worked on at a time and o_in_ready is
// high only while idle; a finished result waits in the output register, so the
// next request may be taken before the previous result is collected. Timing is
// set by the single read port and the one shared comparator: an insert reads
// and moves one parent per level climbed; a full or empty case goes straight to
// the result; a pop reads the root and then the last key, and each level of
// the sift-down takes one read per child, one compare of the children and one
// compare against the sifting key, ending with a write of the sifting key.
module binary_max_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [KEY_PORT_W-1:0] i_key,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [KEY_PORT_W-1:0]      o_out_key,
    output logic [STATUS_W-1:0]        o_status,
    output logic [OCC_W-1:0]           o_occupancy
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // store index width
    localparam int CW = $clog2(DEPTH + 1);                  // key count width
    localparam int LW = IW + 2;                             // child index width

    // One-hot sequencer states
    typedef enum logic [8:0] {
        S_IDLE     = 9'b0_0000_0001,
        S_UP       = 9'b0_0000_0010,
        S_WR_KEY   = 9'b0_0000_0100,
        S_POP_TOP  = 9'b0_0000_1000,
        S_POP_LAST = 9'b0_0001_0000,
        S_DN_L     = 9'b0_0010_0000,
        S_DN_R     = 9'b0_0100_0000,
        S_DN_K     = 9'b0_1000_0000,
        S_RESP     = 9'b1_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_at, n_at;
    logic [IW-1:0]        r_pick_at, n_pick_at;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_pick, n_pick;
    logic [KEY_WIDTH-1:0] r_okey, n_okey;
    logic [STATUS_W-1:0]  r_st, n_st;

    logic                  r_o_valid;
    logic [KEY_PORT_W-1:0] r_o_key;
    logic [STATUS_W-1:0]   r_o_st;
    logic [OCC_W-1:0]      r_o_occ;

    // Heap store: one write and one registered read per cycle
    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;
    logic                 w_we, w_re;
    logic [IW-1:0]        w_waddr, w_raddr;
    logic [KEY_WIDTH-1:0] w_wdata;

    logic                 w_in_acc;
    logic                 w_out_load;
    logic [KEY_WIDTH-1:0] w_key_in;
    logic [IW-1:0]        w_cnt_at;
    logic [IW-1:0]        w_par_cnt;
    logic [IW-1:0]        w_par_at;
    logic [LW-1:0]        w_l, w_r, w_nl, w_n;
    t_cmp_sel             w_cmp_sel;
    logic                 w_lt;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_RESP) && (!r_o_valid || i_out_ready);

    // Keep the key to the stored width
    assign w_key_in  = KEY_WIDTH'(i_key);

    // Tree arithmetic: parent of i is (i-1)/2, children are 2i+1 and 2i+2
    assign w_cnt_at  = r_cnt[IW-1:0];
    assign w_par_cnt = (w_cnt_at - IW'(1)) >> 1;
    assign w_par_at  = (r_at - IW'(1)) >> 1;
    assign w_l       = {1'b0, r_at, 1'b1};
    assign w_r       = w_l + LW'(1);
    assign w_nl      = {1'b0, r_pick_at, 1'b1};
    assign w_n       = LW'(r_cnt);

    always_comb begin
        unique case (r_state)
            S_DN_R:  w_cmp_sel = CMP_CHILD;
            S_DN_K:  w_cmp_sel = CMP_KEY;
            default: w_cmp_sel = CMP_UP;
        endcase
    end

    bmhq_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_sel   (w_cmp_sel),
        .i_rdata (r_rdata),
        .i_key   (r_key),
        .i_pick  (r_pick),
        .o_lt    (w_lt)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_at      = r_at;
        n_pick_at = r_pick_at;
        n_key     = r_key;
        n_pick    = r_pick;
        n_okey    = r_okey;
        n_st      = r_st;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_waddr   = r_at;
        w_raddr   = r_at;
        w_wdata   = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_okey = '0;
                    n_st   = ST_OK;
                    n_key  = w_key_in;
                    if (i_req_type == REQ_INSERT) begin
                        if (r_cnt >= CW'(DEPTH)) begin
                            // drop the key, state unchanged
                            n_st    = ST_FULL;
                            n_state = S_RESP;
                        end else if (r_cnt == '0) begin
                            w_we    = 1'b1;
                            w_waddr = '0;
                            w_wdata = w_key_in;
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_RESP;
                        end else begin
                            n_at    = w_cnt_at;
                            w_re    = 1'b1;
                            w_raddr = w_par_cnt;
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_RESP;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = '0;
                            n_cnt   = r_cnt - CW'(1);
                            n_state = S_POP_TOP;
                        end
                    end
                end
            end

            S_UP: begin
                // r_rdata holds the parent of r_at
                if (w_lt) begin
                    w_we    = 1'b1;
                    w_waddr = r_at;
                    w_wdata = r_rdata;
                    n_at    = w_par_at;
                    if (w_par_at == '0) begin
                        n_state = S_WR_KEY;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = (w_par_at - IW'(1)) >> 1;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_at;
                    w_wdata = r_key;
                    n_state = S_RESP;
                end
            end

            S_WR_KEY: begin
                w_we    = 1'b1;
                w_waddr = r_at;
                w_wdata = r_key;
                n_state = S_RESP;
            end

            S_POP_TOP: begin
                n_okey = r_rdata;
                if (r_cnt == '0) begin
                    n_state = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_cnt[IW-1:0];
                    n_state = S_POP_LAST;
                end
            end

            S_POP_LAST: begin
                // the last key sifts down from the root
                n_key = r_rdata;
                n_at  = '0;
                if (r_cnt == CW'(1)) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = r_rdata;
                    n_state = S_RESP;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = IW'(1);
                    n_state = S_DN_L;
                end
            end

            S_DN_L: begin
                n_pick    = r_rdata;
                n_pick_at = w_l[IW-1:0];
                if (w_r < w_n) begin
                    w_re    = 1'b1;
                    w_raddr = w_r[IW-1:0];
                    n_state = S_DN_R;
                end else begin
                    n_state = S_DN_K;
                end
            end

            S_DN_R: begin
                // right child wins only when strictly greater
                if (w_lt) begin
                    n_pick    = r_rdata;
                    n_pick_at = w_r[IW-1:0];
                end
                n_state = S_DN_K;
            end

            S_DN_K: begin
                if (w_lt) begin
                    w_we    = 1'b1;
                    w_waddr = r_at;
                    w_wdata = r_pick;
                    n_at    = r_pick_at;
                    if (w_nl < w_n) begin
                        w_re    = 1'b1;
                        w_raddr = w_nl[IW-1:0];
                        n_state = S_DN_L;
                    end else begin
                        n_state = S_WR_KEY;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_at;
                    w_wdata = r_key;
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                // hold until the output register is free
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_at      <= n_at;
        r_pick_at <= n_pick_at;
        r_key     <= n_key;
        r_pick    <= n_pick;
        r_okey    <= n_okey;
        r_st      <= n_st;
        if (w_out_load) begin
            r_o_key <= KEY_PORT_W'(r_okey);
            r_o_st  <= r_st;
            r_o_occ <= OCC_W'(r_cnt);
        end
    end

    // Heap store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_key   = r_o_key;
    assign o_status    = r_o_st;
    assign o_occupancy = r_o_occ;

    // Count never exceeds the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("heap count beyond depth");

    // Sift-up never runs at the root
    a_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_at != '0))
        else $error("sift-up at root");

    // The picked child always lies inside the held keys
    a_pick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_K) |-> (LW'(r_pick_at) < w_n))
        else $error("picked child beyond count");

    // A pop on an empty heap returns a zero key
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_out_key == '0))
        else $error("empty pop with non-zero key");

endmodule

`default_nettype wire
